// ----- rtl/rsa_pkg.sv -----
// rsa_pkg: shared constants, command codes and the fp16 widening function
// for the row scatter-accumulate block. No dependencies.
package rsa_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 4;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        CMD_ACC   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_ROW_LENGTH    = 2'd0;
    localparam logic [1:0] REG_ROWS_IN_USE   = 2'd1;
    localparam logic [1:0] REG_SOURCE_FORMAT = 2'd2;

    // Exact fp16 -> fp32, subnormals normalised
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  p;
        logic [3:0]  sh;
        logic [9:0]  nman;
        logic [7:0]  e;
        logic [31:0] r;
        ex  = h[14:10];
        man = h[9:0];
        p   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) p = 4'(i);
        end
        sh   = 4'd10 - p;
        nman = man << sh;
        e    = 8'd113 - {4'd0, sh};
        if (ex == 5'h1F)
            r = {h[15], 8'hFF, man, 13'd0};
        else if (ex == 5'd0 && man == 10'd0)
            r = {h[15], 31'd0};
        else if (ex == 5'd0)
            r = {h[15], e, nman, 13'd0};
        else
            r = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
        return r;
    endfunction

endpackage

// ----- rtl/row_scatter_accumulate.sv -----
// row_scatter_accumulate: top level. fp32 accumulator table in one
// synchronous memory, read-add-write sequencer, APB register port.
// Depends on rsa_pkg and rsa_fadd.

// One transaction at a time: start is taken when busy is low and done pulses
// for one cycle with the result; it cannot be held off. A read passes the
// memory read register, an accumulate the memory read, six-stage fp32 adder
// and write-back; an out-of-range access, a clear or an unused command gets
// done in the cycle after start. A clear then sweeps the 4096-entry table one
// entry a cycle, busy high to its end; the same sweep runs after reset before
// the first start is taken. Register writes are accepted at any time.
module row_scatter_accumulate (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   cmd,
    input  logic [rsa_pkg::ROW_W-1:0]    row_index,
    input  logic [rsa_pkg::COL_W-1:0]    column,
    input  logic [31:0]                  value,
    output logic                         done,
    output logic [31:0]                  read_value,
    output logic                         range_error,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rsa_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_ADD   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0] row_length_reg;
    logic [6:0] rows_in_use_reg;
    logic       source_format_reg;

    logic [31:0] mem [rsa_pkg::DEPTH];
    logic [31:0] rdata_reg;
    logic        mem_we;
    logic [rsa_pkg::ADDR_W-1:0] waddr;
    logic [31:0] wdata;

    rsa_pkg::cmd_t              cmd_reg;
    logic [rsa_pkg::ADDR_W-1:0] addr_reg;
    logic [31:0]                src_reg;
    logic [rsa_pkg::ADDR_W-1:0] clr_cnt_reg;

    logic        done_reg, done_next;
    logic [31:0] rv_reg, rv_next;
    logic        err_reg, err_next;

    logic        accept;
    logic        in_range;
    logic        add_valid;
    logic [31:0] add_sum;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg    <= 7'd64;
            rows_in_use_reg   <= 7'd64;
            source_format_reg <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                rsa_pkg::REG_ROW_LENGTH:    row_length_reg    <= pwdata[6:0];
                rsa_pkg::REG_ROWS_IN_USE:   rows_in_use_reg   <= pwdata[6:0];
                rsa_pkg::REG_SOURCE_FORMAT: source_format_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            rsa_pkg::REG_ROW_LENGTH:    prdata = {25'd0, row_length_reg};
            rsa_pkg::REG_ROWS_IN_USE:   prdata = {25'd0, rows_in_use_reg};
            rsa_pkg::REG_SOURCE_FORMAT: prdata = {31'd0, source_format_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // sequencer
    assign busy     = state_reg != S_IDLE;
    assign accept   = start && !busy;
    assign in_range = ({1'b0, row_index} < rows_in_use_reg) &&
                      ({1'b0, column} < row_length_reg);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        rv_next    = 32'd0;
        err_next   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == rsa_pkg::ADDR_W'(rsa_pkg::DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        rsa_pkg::CMD_ACC, rsa_pkg::CMD_READ:
                        begin
                            if (in_range)
                                state_next = S_READ;
                            else
                            begin
                                done_next = 1'b1;
                                err_next  = 1'b1;
                            end
                        end
                        rsa_pkg::CMD_CLEAR:
                        begin
                            done_next  = 1'b1;
                            state_next = S_CLEAR;
                        end
                        default: done_next = 1'b1;
                    endcase
                end
            end
            S_READ:
            begin
                if (cmd_reg == rsa_pkg::CMD_READ)
                begin
                    done_next  = 1'b1;
                    rv_next    = rdata_reg;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                if (add_valid)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            else
                clr_cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        rv_reg  <= rv_next;
        err_reg <= err_next;
        if (accept)
        begin
            cmd_reg  <= rsa_pkg::cmd_t'(cmd);
            addr_reg <= {row_index, column};
            src_reg  <= source_format_reg ? rsa_pkg::half_to_single(value[15:0]) : value;
        end
    end

    // accumulator table
    assign mem_we = (state_reg == S_CLEAR) || (state_reg == S_ADD && add_valid);
    assign waddr  = (state_reg == S_CLEAR) ? clr_cnt_reg : addr_reg;
    assign wdata  = (state_reg == S_CLEAR) ? 32'd0 : add_sum;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[{row_index, column}];
    end

    rsa_fadd u_fadd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (state_reg == S_READ && cmd_reg == rsa_pkg::CMD_ACC),
        .a         (rdata_reg),
        .b         (src_reg),
        .out_valid (add_valid),
        .sum       (add_sum)
    );

    assign done        = done_reg;
    assign read_value  = rv_reg;
    assign range_error = err_reg;

endmodule

// ----- rtl/rsa_fadd.sv -----
// rsa_fadd: six-stage pipelined IEEE fp32 adder, round to nearest even,
// NaN results canonicalised to quiet NaN. Uses rsa_pkg.
module rsa_fadd (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        out_valid,
    output logic [31:0] sum
);

    logic [5:0] vld_reg;

    // stage 1: unpack, order by magnitude
    logic        s1_spec_reg;
    logic [31:0] s1_spec_val_reg;
    logic        s1_sign_reg;
    logic        s1_sub_reg;
    logic [7:0]  s1_e_reg;
    logic [23:0] s1_ml_reg;
    logic [23:0] s1_ms_reg;
    logic [7:0]  s1_d_reg;

    logic [7:0]  ea, eb;
    logic        nan_a, nan_b, inf_a, inf_b;
    logic        a_big;
    logic [31:0] big, sml;
    logic [7:0]  el_eff, es_eff;

    always_comb
    begin
        ea    = a[30:23];
        eb    = b[30:23];
        nan_a = (ea == 8'hFF) && (a[22:0] != 23'd0);
        nan_b = (eb == 8'hFF) && (b[22:0] != 23'd0);
        inf_a = (ea == 8'hFF) && (a[22:0] == 23'd0);
        inf_b = (eb == 8'hFF) && (b[22:0] == 23'd0);
        a_big = a[30:0] >= b[30:0];
        big   = a_big ? a : b;
        sml   = a_big ? b : a;
        el_eff = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es_eff = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    end

    always_ff @(posedge clk)
    begin
        s1_spec_reg <= nan_a | nan_b | inf_a | inf_b;
        if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31])))
            s1_spec_val_reg <= rsa_pkg::QNAN;
        else if (inf_a)
            s1_spec_val_reg <= a;
        else
            s1_spec_val_reg <= b;
        s1_sign_reg <= big[31];
        s1_sub_reg  <= a[31] ^ b[31];
        s1_e_reg    <= el_eff;
        s1_ml_reg   <= {big[30:23] != 8'd0, big[22:0]};
        s1_ms_reg   <= {sml[30:23] != 8'd0, sml[22:0]};
        s1_d_reg    <= el_eff - es_eff;
    end

    // stage 2: align smaller operand, guard/round/sticky
    logic        s2_spec_reg;
    logic [31:0] s2_spec_val_reg;
    logic        s2_sign_reg;
    logic        s2_sub_reg;
    logic [7:0]  s2_e_reg;
    logic [26:0] s2_ml_reg;
    logic [26:0] s2_ms_reg;

    logic [26:0] ext, al, mask;

    always_comb
    begin
        ext  = {s1_ms_reg, 3'b000};
        mask = (27'd1 << s1_d_reg[4:0]) - 27'd1;
        if (s1_d_reg >= 8'd27)
            al = {26'd0, |s1_ms_reg};
        else
        begin
            al = ext >> s1_d_reg[4:0];
            al[0] = al[0] | (|(ext & mask));
        end
    end

    always_ff @(posedge clk)
    begin
        s2_spec_reg     <= s1_spec_reg;
        s2_spec_val_reg <= s1_spec_val_reg;
        s2_sign_reg     <= s1_sign_reg;
        s2_sub_reg      <= s1_sub_reg;
        s2_e_reg        <= s1_e_reg;
        s2_ml_reg       <= {s1_ml_reg, 3'b000};
        s2_ms_reg       <= al;
    end

    // stage 3: add or subtract magnitudes
    logic        s3_spec_reg;
    logic [31:0] s3_spec_val_reg;
    logic        s3_sign_reg;
    logic        s3_sub_reg;
    logic [7:0]  s3_e_reg;
    logic [27:0] s3_sum_reg;

    always_ff @(posedge clk)
    begin
        s3_spec_reg     <= s2_spec_reg;
        s3_spec_val_reg <= s2_spec_val_reg;
        s3_sign_reg     <= s2_sign_reg;
        s3_sub_reg      <= s2_sub_reg;
        s3_e_reg        <= s2_e_reg;
        if (s2_sub_reg)
            s3_sum_reg <= {1'b0, s2_ml_reg} - {1'b0, s2_ms_reg};
        else
            s3_sum_reg <= {1'b0, s2_ml_reg} + {1'b0, s2_ms_reg};
    end

    // stage 4: leading one search, shift amount clamped at the subnormal edge
    logic        s4_spec_reg;
    logic [31:0] s4_spec_val_reg;
    logic        s4_sign_reg;
    logic        s4_sub_reg;
    logic [7:0]  s4_e_reg;
    logic [27:0] s4_sum_reg;
    logic        s4_zero_reg;
    logic        s4_right_reg;
    logic [4:0]  s4_sh_reg;

    logic [4:0] lead;
    logic [4:0] lz;
    logic [7:0] emax;
    logic [4:0] sh;

    always_comb
    begin
        lead = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (s3_sum_reg[i]) lead = 5'(i);
        end
        lz   = 5'd26 - lead;
        emax = s3_e_reg - 8'd1;
        sh   = ({3'd0, lz} > emax) ? emax[4:0] : lz;
    end

    always_ff @(posedge clk)
    begin
        s4_spec_reg     <= s3_spec_reg;
        s4_spec_val_reg <= s3_spec_val_reg;
        s4_sign_reg     <= s3_sign_reg;
        s4_sub_reg      <= s3_sub_reg;
        s4_e_reg        <= s3_e_reg;
        s4_sum_reg      <= s3_sum_reg;
        s4_zero_reg     <= s3_sum_reg == 28'd0;
        s4_right_reg    <= s3_sum_reg[27];
        s4_sh_reg       <= sh;
    end

    // stage 5: normalise
    logic        s5_spec_reg;
    logic [31:0] s5_spec_val_reg;
    logic        s5_sign_reg;
    logic        s5_sub_reg;
    logic        s5_zero_reg;
    logic [26:0] s5_m_reg;
    logic [8:0]  s5_e_reg;

    always_ff @(posedge clk)
    begin
        s5_spec_reg     <= s4_spec_reg;
        s5_spec_val_reg <= s4_spec_val_reg;
        s5_sign_reg     <= s4_sign_reg;
        s5_sub_reg      <= s4_sub_reg;
        s5_zero_reg     <= s4_zero_reg;
        if (s4_right_reg)
        begin
            s5_m_reg <= {s4_sum_reg[27:2], s4_sum_reg[1] | s4_sum_reg[0]};
            s5_e_reg <= {1'b0, s4_e_reg} + 9'd1;
        end
        else
        begin
            s5_m_reg <= s4_sum_reg[26:0] << s4_sh_reg;
            s5_e_reg <= {1'b0, s4_e_reg} - {4'd0, s4_sh_reg};
        end
    end

    // stage 6: round to nearest even and pack
    logic [31:0] res_reg;
    logic        up;
    logic [24:0] m25;
    logic [8:0]  e2;
    logic        hid;
    logic [22:0] frac;
    logic [31:0] res;

    always_comb
    begin
        up  = s5_m_reg[2] & (s5_m_reg[1] | s5_m_reg[0] | s5_m_reg[3]);
        m25 = {1'b0, s5_m_reg[26:3]} + {24'd0, up};
        if (m25[24])
        begin
            e2   = s5_e_reg + 9'd1;
            hid  = 1'b1;
            frac = 23'd0;
        end
        else
        begin
            e2   = s5_e_reg;
            hid  = m25[23];
            frac = m25[22:0];
        end
        if (s5_spec_reg)
            res = s5_spec_val_reg;
        else if (s5_zero_reg)
            res = {s5_sub_reg ? 1'b0 : s5_sign_reg, 31'd0};
        else if (hid && e2 >= 9'd255)
            res = {s5_sign_reg, 8'hFF, 23'd0};
        else if (hid)
            res = {s5_sign_reg, e2[7:0], frac};
        else
            res = {s5_sign_reg, 8'd0, frac};
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 6'd0;
        else
            vld_reg <= {vld_reg[4:0], in_valid};
    end

    assign out_valid = vld_reg[5];
    assign sum       = res_reg;

endmodule
